// File: rtl/pkcrc_pkg.sv
// shared types, constants and the byte-wide crc update for the cksum block
package pkcrc_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [31:0] CRC_POLY    = 32'h04C11DB7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       carries_byte;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qhead_type;

   typedef enum logic [0:0] {
      ST_RUN,
      ST_LEN
   } state_type;

   // msb-first crc-32 over one byte, eight shift steps
   function automatic logic [31:0] crc_byte(input logic [31:0] rem, input logic [7:0] b);
      logic [31:0] v;
      int          k;
      v = rem ^ {b, 24'h000000};
      for (k = 0; k < 8; k++) begin
         if (v[31]) begin
            v = {v[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[30:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// File: rtl/pkcrc_front.sv
// input side: accepts items, drops empty ones and queues the rest for the engine
module pkcrc_front #(
   parameter int unsigned Depth = pkcrc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_carries_byte,
   input  logic                  req_last,
   output logic                  req_full,
   input  logic                  take,
   output pkcrc_pkg::qhead_type  head
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   pkcrc_pkg::entry_type entries_ff [Depth];
   pkcrc_pkg::entry_type entry_in;

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            accept;
   logic            wr_en;
   logic            rd_en;

   assign req_full = (count_ff == CntW'(Depth));
   assign accept   = req_push & ~req_full;
   // an item with neither byte nor end changes nothing, so it never enters the queue
   assign wr_en    = accept & (req_carries_byte | req_last);
   assign rd_en    = take & (count_ff != '0);

   assign entry_in.data_byte    = req_data_byte;
   assign entry_in.carries_byte = req_carries_byte;
   assign entry_in.last         = req_last;

   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill count above depth");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not follow a write");
`endif

endmodule

// File: rtl/pkcrc_back.sv
// engine: runs the crc over queued bytes, appends the length bytes and holds the result
module pkcrc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pkcrc_pkg::qhead_type head,
   output logic                 take,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [31:0]          rsp_checksum,
   output logic [31:0]          rsp_byte_count
);

   pkcrc_pkg::state_type state_ff, state_in;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] len_ff, len_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_sum_ff, out_sum_in;
   logic [31:0] out_count_ff, out_count_in;
   logic [7:0]  crc_src;
   logic [31:0] crc_next;
   logic [31:0] cnt_inc;
   logic        slot_free;

   assign slot_free = ~out_valid_ff | rsp_pop;
   assign cnt_inc   = cnt_ff + 32'd1;
   assign crc_src   = (state_ff == pkcrc_pkg::ST_LEN) ? len_ff[7:0] : head.entry.data_byte;
   assign crc_next  = pkcrc_pkg::crc_byte(rem_ff, crc_src);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pkcrc_pkg::ST_RUN: begin
            if (head.valid && head.entry.last) begin
               state_in = pkcrc_pkg::ST_LEN;
            end
         end
         pkcrc_pkg::ST_LEN: begin
            if ((len_ff == 32'd0) && slot_free) begin
               state_in = pkcrc_pkg::ST_RUN;
            end
         end
         default: state_in = pkcrc_pkg::ST_RUN;
      endcase
   end

   // datapath and outputs
   always_comb begin
      take         = 1'b0;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      out_sum_in   = out_sum_ff;
      out_count_in = out_count_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      case (state_ff)
         pkcrc_pkg::ST_RUN: begin
            take = 1'b1;
            if (head.valid) begin
               if (head.entry.carries_byte) begin
                  rem_in = crc_next;
                  cnt_in = cnt_inc;
               end
               if (head.entry.last) begin
                  len_in = head.entry.carries_byte ? cnt_inc : cnt_ff;
               end
            end
         end
         pkcrc_pkg::ST_LEN: begin
            // feed count bytes, low byte first, while the remaining count is nonzero
            if (len_ff != 32'd0) begin
               rem_in = crc_next;
               len_in = {8'h00, len_ff[31:8]};
            end else if (slot_free) begin
               out_sum_in   = ~rem_ff;
               out_count_in = cnt_ff;
               out_valid_in = 1'b1;
               rem_in       = 32'd0;
               cnt_in       = 32'd0;
            end
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkcrc_pkg::ST_RUN;
         rem_ff       <= 32'd0;
         cnt_ff       <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      out_sum_ff   <= out_sum_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_empty      = ~out_valid_ff;
   assign rsp_checksum   = out_sum_ff;
   assign rsp_byte_count = out_count_ff;

`ifndef SYNTHESIS
   a_no_take_in_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pkcrc_pkg::ST_LEN) |-> !take)
      else $error("queue read while appending length bytes");

   a_result_from_len: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == pkcrc_pkg::ST_LEN))
      else $error("result loaded outside the finishing state");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pkcrc_pkg::ST_LEN && len_ff == 32'd0 && slot_free)
      |=> (rem_ff == 32'd0 && cnt_ff == 32'd0 && state_ff == pkcrc_pkg::ST_RUN))
      else $error("remainder and count not cleared after a result");
`endif

endmodule

// File: rtl/posix_cksum_crc32.sv
// posix cksum crc-32 top level: input queue feeding the crc engine
// result path: queue, run state, length state (feeds k = 0..4 count bytes), output slot register
// throughput: one byte item per cycle; a last item stalls the engine until its sum is loaded
// the engine's single crc byte network is shared by message bytes and length bytes
// reset: synchronous, active high; empties the queue and output slot, clears remainder and count
module posix_cksum_crc32 #(
   parameter int unsigned QueueDepth = pkcrc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   input  logic        req_carries_byte,
   input  logic        req_last,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_checksum,
   output logic [31:0] rsp_byte_count
);

   pkcrc_pkg::qhead_type head;
   logic                 take;

   pkcrc_front #(
      .Depth(QueueDepth)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_data_byte   (req_data_byte),
      .req_carries_byte(req_carries_byte),
      .req_last        (req_last),
      .req_full        (req_full),
      .take            (take),
      .head            (head)
   );

   pkcrc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .take          (take),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_checksum  (rsp_checksum),
      .rsp_byte_count(rsp_byte_count)
   );

endmodule

// File: sim/posix_cksum_crc32_checker.sv
// checker for the cksum block: predicts each checksum from accepted items and compares results
`timescale 1ns / 100ps

module posix_cksum_crc32_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   input  logic        req_carries_byte,
   input  logic        req_last,
   input  logic        req_full,
   input  logic        rsp_pop,
   input  logic        rsp_empty,
   input  logic [31:0] rsp_checksum,
   input  logic [31:0] rsp_byte_count,
   output int          fail_count,
   output int          sums_waiting
);

   localparam logic [31:0] CKSUM_POLY = 32'h04C11DB7;

   typedef struct packed {
      logic [31:0] checksum;
      logic [31:0] byte_count;
   } cksum_result;

   cksum_result sums_q[$];
   logic [31:0] msg_crc;
   logic [31:0] msg_len;

   // one byte into the remainder, msb first, bit at a time
   function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] acc;
      int          i;
      acc = crc;
      for (i = 7; i >= 0; i--) begin
         if (acc[31] ^ b[i]) begin
            acc = {acc[30:0], 1'b0} ^ CKSUM_POLY;
         end else begin
            acc = {acc[30:0], 1'b0};
         end
      end
      return acc;
   endfunction

   // append the nonzero-prefixed length bytes, low byte first, then invert
   function automatic cksum_result finish_sum(input logic [31:0] crc, input logic [31:0] len);
      logic [31:0] acc;
      logic [31:0] rest;
      cksum_result r;
      acc  = crc;
      rest = len;
      while (rest != 32'd0) begin
         acc  = fold_byte(acc, rest[7:0]);
         rest = rest >> 8;
      end
      r.checksum   = ~acc;
      r.byte_count = len;
      return r;
   endfunction

   initial begin
      fail_count   = 0;
      sums_waiting = 0;
   end

   always @(posedge clock) begin : watch
      cksum_result want;
      logic [31:0] next_crc;
      logic [31:0] next_len;
      if (reset) begin
         sums_q.delete();
         msg_crc <= 32'd0;
         msg_len <= 32'd0;
      end else begin
         if (req_push && !req_full) begin
            next_crc = msg_crc;
            next_len = msg_len;
            if (req_carries_byte) begin
               next_crc = fold_byte(next_crc, req_data_byte);
               next_len = next_len + 32'd1;
            end
            if (req_last) begin
               sums_q.push_back(finish_sum(next_crc, next_len));
               next_crc = 32'd0;
               next_len = 32'd0;
            end
            msg_crc <= next_crc;
            msg_len <= next_len;
         end
         if (rsp_pop && !rsp_empty) begin
            if (sums_q.size() == 0) begin
               $error("unexpected result: checksum %h byte_count %h",
                      rsp_checksum, rsp_byte_count);
               fail_count++;
            end else begin
               want = sums_q.pop_front();
               if (rsp_checksum !== want.checksum) begin
                  $error("checksum mismatch: expected %h, actual %h",
                         want.checksum, rsp_checksum);
                  fail_count++;
               end
               if (rsp_byte_count !== want.byte_count) begin
                  $error("byte_count mismatch: expected %0d, actual %0d",
                         want.byte_count, rsp_byte_count);
                  fail_count++;
               end
            end
         end
      end
      sums_waiting <= sums_q.size();
   end

endmodule

// File: sim/posix_cksum_crc32_tb.sv
// testbench top for the cksum block: clock, reset, item stimulus, result popping and verdict
`timescale 1ns / 100ps

module posix_cksum_crc32_tb;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_push         = 1'b0;
   logic [7:0]  req_data_byte    = 8'h00;
   logic        req_carries_byte = 1'b0;
   logic        req_last         = 1'b0;
   logic        req_full;
   logic        rsp_pop          = 1'b0;
   logic        rsp_empty;
   logic [31:0] rsp_checksum;
   logic [31:0] rsp_byte_count;

   int fail_count;
   int sums_waiting;
   int push_idle_pct = 21;
   int pop_idle_pct  = 51;
   int sent_items    = 0;
   int sent_msgs     = 0;

   always #5 clock = ~clock;

   posix_cksum_crc32 DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data_byte    (req_data_byte),
      .req_carries_byte (req_carries_byte),
      .req_last         (req_last),
      .req_full         (req_full),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_checksum     (rsp_checksum),
      .rsp_byte_count   (rsp_byte_count)
   );

   posix_cksum_crc32_checker sum_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data_byte    (req_data_byte),
      .req_carries_byte (req_carries_byte),
      .req_last         (req_last),
      .req_full         (req_full),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_checksum     (rsp_checksum),
      .rsp_byte_count   (rsp_byte_count),
      .fail_count       (fail_count),
      .sums_waiting     (sums_waiting)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   // hold the item until the queue takes it
   task automatic send_item(input logic [7:0] b, input logic carries, input logic fin);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_data_byte    <= b;
      req_carries_byte <= carries;
      req_last         <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (carries || fin) sent_items++;
      if (fin) sent_msgs++;
   endtask

   task automatic send_message(input int unsigned len);
      int unsigned i;
      logic        end_alone;
      logic [7:0]  b;
      end_alone = 1'($urandom_range(1));
      for (i = 0; i < len; i++) begin
         // stray item with neither byte nor end now and then
         if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         b = 8'($urandom_range(255));
         if ($urandom_range(7) == 0) b = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         send_item(b, 1'b1, (i == len - 1) && !end_alone);
      end
      if (len == 0 || end_alone) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   initial begin : stimulus
      int unsigned len;
      int unsigned pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty message, single-byte extremes, stray items, end marker after bytes
      send_item(8'h5A, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'hC3, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'hAA, 1'b1, 1'b1);

      // a count with a zero low byte gives two length bytes
      send_message(256);

      while (sent_items < 950 || sent_msgs < 40) begin
         if (sent_items >= 634) begin
            push_idle_pct = 0;
            pop_idle_pct  = 0;
         end else if (sent_items >= 317) begin
            push_idle_pct = 51;
            pop_idle_pct  = 21;
         end
         pick = $urandom_range(99);
         if (pick < 90) begin
            len = $urandom_range(10);
         end else if (pick < 98) begin
            len = $urandom_range(160, 11);
         end else begin
            len = $urandom_range(360, 256);
         end
         send_message(len);
      end
      req_push <= 1'b0;

      repeat (2) @(posedge clock);
      while (sums_waiting != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0 && sums_waiting == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
